@@ hdl/pca_pkg.sv @@
// Package for the pixel channel ALU: payload structs, opcodes, constants.
// No dependencies.
`default_nettype none
package pca_pkg;
  localparam int CompMaxDefault = 255;
  localparam int DivStages = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;
  localparam logic [2:0] OP_WRAP = 3'd6;
  localparam logic [2:0] OP_GREY = 3'd7;

  typedef struct packed {
    logic [2:0] opcode;
    logic signed [31:0] a_red;
    logic signed [31:0] a_green;
    logic signed [31:0] a_blue;
    logic a_is_grey;
    logic signed [31:0] b_red;
    logic signed [31:0] b_green;
    logic signed [31:0] b_blue;
  } pca_in_t;

  typedef struct packed {
    logic signed [31:0] out_red;
    logic signed [31:0] out_green;
    logic signed [31:0] out_blue;
    logic out_is_grey;
    logic math_error;
  } pca_out_t;

  // per-lane sideband fields (op, limit flag, grey flag)
  typedef struct packed {
    logic [2:0] op;
    logic lim;
    logic is_grey;
  } pca_ctl_t;
endpackage
`default_nettype wire

@@ hdl/pixel_channel_alu_unit.sv @@
// Top level of the pixel channel ALU: three lanes, control pipe, merge and output skid.
// Depends on pca_pkg and pca_lane.
`default_nettype none
// Fully pipelined: one pixel pair per cycle while in_ready is high. The depth is set by the
// bit-per-stage divider and root unit in each lane. The pipeline advances whenever its last
// stage is empty or the skid queue is not full; a two-entry skid holds results under
// out_ready stalls.
module pixel_channel_alu_unit
  import pca_pkg::*;
#(
  parameter int COMPONENT_MAX = CompMaxDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire pca_in_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output pca_out_t out_data,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  localparam int LAT = DivStages + 4;
  logic wrap_r;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] gry_r;
  logic en;
  logic lim;
  logic signed [31:0] gsum;
  logic signed [31:0] r0, r1, r2;
  logic e0, e1, e2;

  // skid: two entries
  pca_out_t sk_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;

  assign en = !vld_r[LAT-1] || (cnt_r != 2'd2);
  assign in_ready = en;
  assign lim = wrap_r || (in_data.opcode == OP_WRAP);
  assign gsum = 32'(in_data.a_red + in_data.a_green + in_data.a_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= 1'b0;
      vld_r <= '0;
    end else begin
      if (cfg_we) wrap_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) gry_r <= {gry_r[LAT-2:0], in_data.a_is_grey};
  end

  pca_lane #(.COMPONENT_MAX(COMPONENT_MAX)) u_red (
    .clk, .en, .op(in_data.opcode), .lim, .a(in_data.a_red), .b(in_data.b_red),
    .grey_sum(gsum), .res(r0), .err(e0));
  pca_lane #(.COMPONENT_MAX(COMPONENT_MAX)) u_green (
    .clk, .en, .op(in_data.opcode), .lim, .a(in_data.a_green), .b(in_data.b_green),
    .grey_sum(gsum), .res(r1), .err(e1));
  pca_lane #(.COMPONENT_MAX(COMPONENT_MAX)) u_blue (
    .clk, .en, .op(in_data.opcode), .lim, .a(in_data.a_blue), .b(in_data.b_blue),
    .grey_sum(gsum), .res(r2), .err(e2));

  // merge lanes into the skid queue
  logic push, pop;
  pca_out_t mrg;
  assign mrg = '{out_red: r0, out_green: r1, out_blue: r2,
                 out_is_grey: gry_r[LAT-1], math_error: e0 | e1 | e2};
  assign pop = out_valid && out_ready;
  assign push = en && vld_r[LAT-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end
  always_ff @(posedge clk) begin
    if (push) sk_r[wp_r] <= mrg;
  end
  assign out_valid = (cnt_r != 2'd0);
  assign out_data = sk_r[rp_r];
endmodule
`default_nettype wire

@@ hdl/pca_lane.sv @@
// One channel lane: operand prep, pipelined divider/root, multiplier, select, wrap limit.
// Depends on pca_pkg.
`default_nettype none
module pca_lane
  import pca_pkg::*;
#(
  parameter int COMPONENT_MAX = CompMaxDefault
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [2:0] op,
  input  wire logic lim,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire logic signed [31:0] grey_sum,
  output logic signed [31:0] res,
  output logic err
);
  localparam int MW = $clog2(COMPONENT_MAX + 1) + 1;
  localparam logic [32:0] MODV = 33'(COMPONENT_MAX + 1);

  // stage 0: operands for divider (magnitudes), root, quick ops
  logic [31:0] dn_r, dd_r, sq_r, fast_r;
  logic qneg_r, dz_r, sneg_r;
  logic [2:0] op0_r;
  logic lim0_r;
  logic signed [31:0] mul_a_r, mul_b_r;
  logic [31:0] dn_nxt, dd_nxt;
  logic [31:0] fast_nxt;
  logic signed [31:0] dsa, dsb;

  always_comb begin
    dsa = (op == OP_GREY) ? grey_sum : a;
    dsb = (op == OP_GREY) ? 32'sd3 : b;
    dn_nxt = dsa[31] ? 32'(-dsa) : dsa;
    dd_nxt = dsb[31] ? 32'(-dsb) : dsb;
    case (op)
      OP_ADD: fast_nxt = 32'(a + b);
      OP_SUB: fast_nxt = 32'(a - b);
      OP_NEG: fast_nxt = 32'(-a);
      default: fast_nxt = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_r <= dn_nxt;
      dd_r <= dd_nxt;
      qneg_r <= dsa[31] ^ dsb[31];
      dz_r <= (dsb == 32'sd0);
      sq_r <= a;
      sneg_r <= a[31];
      fast_r <= fast_nxt;
      op0_r <= op;
      lim0_r <= lim;
      mul_a_r <= a;
      mul_b_r <= b;
    end
  end

  // restoring divider (one quotient bit per stage) and root (one root bit every other stage)
  logic [31:0] q_r [DivStages+1];
  logic [32:0] rm_r [DivStages+1];
  logic [31:0] n_r [DivStages+1];
  logic [31:0] d_r [DivStages+1];
  logic [15:0] rt_r [DivStages+1];
  logic [33:0] rr_r [DivStages+1];
  logic [31:0] sv_r [DivStages+1];
  logic [31:0] fa_r [DivStages+1];
  logic [31:0] ml_r [DivStages+1];
  logic [2:0] op_r [DivStages+1];
  logic lim_r [DivStages+1];
  logic qn_r [DivStages+1];
  logic dz_p [DivStages+1];
  logic sn_r [DivStages+1];

  always_comb begin
    q_r[0] = '0; rm_r[0] = '0; n_r[0] = dn_r; d_r[0] = dd_r;
    rt_r[0] = '0; rr_r[0] = '0; sv_r[0] = sq_r; fa_r[0] = fast_r;
    ml_r[0] = 32'(mul_a_r * mul_b_r);
    op_r[0] = op0_r; lim_r[0] = lim0_r; qn_r[0] = qneg_r;
    dz_p[0] = dz_r; sn_r[0] = sneg_r;
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [32:0] rm_t;
    logic [33:0] rr_t, tr;
    logic [32:0] q_n; logic [33:0] r_n;
    logic [31:0] q_o, n_o; logic [15:0] rt_o; logic [31:0] sv_o;
    always_comb begin
      rm_t = {rm_r[s][31:0], n_r[s][31]};
      if (rm_t >= {1'b0, d_r[s]}) begin
        q_n = 33'(rm_t - {1'b0, d_r[s]});
        q_o = {q_r[s][30:0], 1'b1};
      end else begin
        q_n = rm_t;
        q_o = {q_r[s][30:0], 1'b0};
      end
      n_o = {n_r[s][30:0], 1'b0};
      // root: two radicand bits every other stage
      rr_t = rr_r[s]; rt_o = rt_r[s]; sv_o = sv_r[s]; r_n = rr_r[s];
      tr = '0;
      if (s % 2 == 0) begin
        rr_t = {rr_r[s][31:0], sv_r[s][31:30]};
        tr = {16'd0, rt_r[s], 2'b01};
        if (rr_t >= tr) begin
          r_n = 34'(rr_t - tr);
          rt_o = {rt_r[s][14:0], 1'b1};
        end else begin
          r_n = rr_t;
          rt_o = {rt_r[s][14:0], 1'b0};
        end
        sv_o = {sv_r[s][29:0], 2'b00};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1] <= q_o; rm_r[s+1] <= q_n; n_r[s+1] <= n_o; d_r[s+1] <= d_r[s];
        rt_r[s+1] <= rt_o; rr_r[s+1] <= r_n; sv_r[s+1] <= sv_o;
        fa_r[s+1] <= fa_r[s]; ml_r[s+1] <= ml_r[s]; op_r[s+1] <= op_r[s];
        lim_r[s+1] <= lim_r[s]; qn_r[s+1] <= qn_r[s]; dz_p[s+1] <= dz_p[s];
        sn_r[s+1] <= sn_r[s];
      end
    end
  end

  // select result
  logic [31:0] sel_r, sel_nxt;
  logic err_r, err_nxt, lim2_r;
  logic [31:0] qv;
  always_comb begin
    qv = qn_r[DivStages] ? 32'(-q_r[DivStages]) : q_r[DivStages];
    err_nxt = 1'b0;
    case (op_r[DivStages])
      OP_MUL: sel_nxt = ml_r[DivStages];
      OP_DIV: begin
        sel_nxt = dz_p[DivStages] ? 32'd0 : qv;
        err_nxt = dz_p[DivStages];
      end
      OP_SQRT: begin
        sel_nxt = sn_r[DivStages] ? 32'd0 : {16'd0, rt_r[DivStages]};
        err_nxt = sn_r[DivStages];
      end
      OP_GREY: sel_nxt = qv;
      default: sel_nxt = fa_r[DivStages];
    endcase
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= sel_nxt; err_r <= err_nxt; lim2_r <= lim_r[DivStages];
    end
  end

  // wrap limit: modulo by constant via short compare/subtract on a reciprocal estimate
  localparam int RS = 48;
  localparam logic [47:0] RECIP = 48'(((64'd1 << RS) + 64'(COMPONENT_MAX)) / 64'(COMPONENT_MAX + 1));
  logic [31:0] x_r; logic pos_r, lim3_r, err3_r;
  logic [63:0] pl, ph;
  always_comb begin
    pl = 64'(sel_r) * 64'(RECIP[23:0]);
    ph = 64'(sel_r) * 64'(RECIP[47:24]);
  end
  // partial products registered, then combined
  logic [63:0] pl_r, ph_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl; ph_r <= ph;
      x_r <= sel_r; pos_r <= !sel_r[31] && (sel_r != 32'd0);
      lim3_r <= lim2_r; err3_r <= err_r;
    end
  end
  logic [79:0] pr; logic [31:0] qe; logic [32:0] rem0;
  logic [31:0] lim_v_nxt; logic [31:0] out_r; logic err4_r;
  always_comb begin
    pr = 80'(pl_r) + (80'(ph_r) << 24);
    qe = 32'(pr >> RS);
    rem0 = 33'({1'b0, x_r} - 33'(64'(qe) * 64'(COMPONENT_MAX + 1)));
    if (rem0[32]) rem0 = 33'(rem0 + MODV);
    else if (rem0 >= MODV) rem0 = 33'(rem0 - MODV);
    lim_v_nxt = !lim3_r ? x_r : (pos_r ? {{(32-MW){1'b0}}, rem0[MW-1:0]} : 32'd0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= lim_v_nxt; err4_r <= err3_r;
    end
  end
  assign res = out_r;
  assign err = err4_r;
endmodule
`default_nettype wire
